>>> sv/depth_pixel_backprojection_unit_macros.svh
// ---------------------------------------------------------------------------
// depth pixel backprojection assertion macros
// shared property wrappers, empty when synthesizing
// ---------------------------------------------------------------------------
`ifndef DEPTH_PIXEL_BACKPROJECTION_UNIT_MACROS_SVH
`define DEPTH_PIXEL_BACKPROJECTION_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define DPBP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpbp assertion failed");

`define DPBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpbp assertion failed");

`else

`define DPBP_ASSERT_SAME(label, ante, cons)

`define DPBP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> sv/dpbp_pkg.sv
// ---------------------------------------------------------------------------
// dpbp_pkg
// widths, register indexes and shared types of the depth backprojection unit
// ---------------------------------------------------------------------------
package dpbp_pkg;

  localparam int PixW   = 12;
  localparam int RawW   = 16;
  localparam int ScaleW = 24;
  localparam int LimW   = 20;
  localparam int CoefW  = 21;
  localparam int RegW   = 63;
  localparam int AddrW  = 3;
  localparam int ProdW  = RawW + ScaleW;
  localparam int DistW  = 28;
  localparam int MulW   = CoefW + PixW + 1;
  localparam int SumW   = MulW + 1;
  localparam int HalfW  = DistW / 2;
  localparam int PartW  = SumW + HalfW + 1;
  localparam int FullW  = 64;
  localparam int FracSh = 18;
  localparam int RndW   = FullW - FracSh;
  localparam int WsumW  = RndW + 1;
  localparam int OutW   = 28;
  localparam int Stages = 5;

  localparam logic [AddrW-1:0] RegDepthScale = 3'd0;
  localparam logic [AddrW-1:0] RegNearLimit  = 3'd1;
  localparam logic [AddrW-1:0] RegFarLimit   = 3'd2;
  localparam logic [AddrW-1:0] RegXCoeffs    = 3'd3;
  localparam logic [AddrW-1:0] RegYCoeffs    = 3'd4;
  localparam logic [AddrW-1:0] RegZCoeffs    = 3'd5;
  localparam logic [AddrW-1:0] RegTrans      = 3'd6;

  localparam logic [ScaleW-1:0] ScaleReset = 24'd16777;
  localparam logic [LimW-1:0]   NearReset  = 20'd82;
  localparam logic [LimW-1:0]   FarReset   = 20'd20480;

  typedef struct packed {
    logic [ScaleW-1:0]     depth_scale;
    logic [LimW-1:0]       near_limit;
    logic [LimW-1:0]       far_limit;
    logic [2:0][RegW-1:0]  coeffs;
    logic [RegW-1:0]       translation;
  } cfg_t;

  typedef struct packed {
    logic [Stages-1:0] load;
  } pipe_ctl_t;

  function automatic logic signed [OutW-1:0] sat_out(input logic signed [WsumW-1:0] v);
    logic signed [WsumW-1:0] hi;
    logic signed [WsumW-1:0] lo;
    hi = WsumW'(signed'({1'b0, {(OutW-1){1'b1}}}));
    lo = WsumW'(signed'({1'b1, {(OutW-1){1'b0}}}));
    if (v > hi) begin
      sat_out = hi[OutW-1:0];
    end else if (v < lo) begin
      sat_out = lo[OutW-1:0];
    end else begin
      sat_out = v[OutW-1:0];
    end
  endfunction

endpackage

>>> sv/dpbp_cfg.sv
// ---------------------------------------------------------------------------
// dpbp_cfg
// configuration register file, write only
// ---------------------------------------------------------------------------
module dpbp_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [dpbp_pkg::AddrW-1:0]  cfg_addr,
  input  logic [dpbp_pkg::RegW-1:0]   cfg_wdata,
  output dpbp_pkg::cfg_t              cfg
);

  dpbp_pkg::cfg_t cfg_r;
  dpbp_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        dpbp_pkg::RegDepthScale: cfg_nxt.depth_scale = cfg_wdata[dpbp_pkg::ScaleW-1:0];
        dpbp_pkg::RegNearLimit:  cfg_nxt.near_limit  = cfg_wdata[dpbp_pkg::LimW-1:0];
        dpbp_pkg::RegFarLimit:   cfg_nxt.far_limit   = cfg_wdata[dpbp_pkg::LimW-1:0];
        dpbp_pkg::RegXCoeffs:    cfg_nxt.coeffs[0]   = cfg_wdata;
        dpbp_pkg::RegYCoeffs:    cfg_nxt.coeffs[1]   = cfg_wdata;
        dpbp_pkg::RegZCoeffs:    cfg_nxt.coeffs[2]   = cfg_wdata;
        dpbp_pkg::RegTrans:      cfg_nxt.translation = cfg_wdata;
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depth_scale <= dpbp_pkg::ScaleReset;
      cfg_r.near_limit  <= dpbp_pkg::NearReset;
      cfg_r.far_limit   <= dpbp_pkg::FarReset;
      cfg_r.coeffs      <= '0;
      cfg_r.translation <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> sv/dpbp_axis.sv
// ---------------------------------------------------------------------------
// dpbp_axis
// one world axis: ray coefficient sum, split distance product, round, offset
// ---------------------------------------------------------------------------
module dpbp_axis (
  input  logic                               clk,
  input  dpbp_pkg::pipe_ctl_t                ctl,
  input  logic [dpbp_pkg::PixW-1:0]          pixel_col,
  input  logic [dpbp_pkg::PixW-1:0]          pixel_row,
  input  logic [dpbp_pkg::RegW-1:0]          coeffs,
  input  logic [dpbp_pkg::CoefW-1:0]         offset,
  input  logic [dpbp_pkg::DistW-1:0]         depth_d,
  input  logic                               keep,
  output logic signed [dpbp_pkg::OutW-1:0]   world
);

  localparam int CW = dpbp_pkg::CoefW;
  localparam int HW = dpbp_pkg::HalfW;

  logic signed [CW-1:0]                 c0;
  logic signed [CW-1:0]                 c1;
  logic signed [CW-1:0]                 c2;
  logic signed [dpbp_pkg::PixW:0]       col_s;
  logic signed [dpbp_pkg::PixW:0]       row_s;
  logic signed [dpbp_pkg::MulW-1:0]     m0_r, m0_nxt;
  logic signed [dpbp_pkg::MulW-1:0]     m1_r, m1_nxt;
  logic signed [dpbp_pkg::SumW-1:0]     s_r, s_nxt;
  logic signed [HW:0]                   d_lo;
  logic signed [HW:0]                   d_hi;
  logic signed [dpbp_pkg::PartW-1:0]    pl_r, pl_nxt;
  logic signed [dpbp_pkg::PartW-1:0]    ph_r, ph_nxt;
  logic signed [dpbp_pkg::FullW-1:0]    p;
  logic signed [dpbp_pkg::RndW-1:0]     r_r, r_nxt;
  logic signed [dpbp_pkg::WsumW-1:0]    wsum;
  logic signed [dpbp_pkg::OutW-1:0]     world_r, world_nxt;

  always_comb begin
    c0     = signed'(coeffs[CW-1:0]);
    c1     = signed'(coeffs[2*CW-1:CW]);
    c2     = signed'(coeffs[3*CW-1:2*CW]);
    col_s  = signed'({1'b0, pixel_col});
    row_s  = signed'({1'b0, pixel_row});
    m0_nxt = dpbp_pkg::MulW'(c0) * dpbp_pkg::MulW'(col_s);
    m1_nxt = dpbp_pkg::MulW'(c1) * dpbp_pkg::MulW'(row_s);
    s_nxt  = dpbp_pkg::SumW'(m0_r) + dpbp_pkg::SumW'(m1_r) + dpbp_pkg::SumW'(c2);
    // distance split in two halves to keep each multiplier narrow
    d_lo   = signed'({1'b0, depth_d[HW-1:0]});
    d_hi   = signed'({1'b0, depth_d[dpbp_pkg::DistW-1:HW]});
    pl_nxt = dpbp_pkg::PartW'(s_r) * dpbp_pkg::PartW'(d_lo);
    ph_nxt = dpbp_pkg::PartW'(s_r) * dpbp_pkg::PartW'(d_hi);
    // round half up to 1/4096 m
    p      = (dpbp_pkg::FullW'(ph_r) <<< HW) + dpbp_pkg::FullW'(pl_r)
           + dpbp_pkg::FullW'(signed'(65'd1 << (dpbp_pkg::FracSh - 1)));
    r_nxt  = p[dpbp_pkg::FullW-1:dpbp_pkg::FracSh];
    wsum   = dpbp_pkg::WsumW'(r_r) + dpbp_pkg::WsumW'(signed'(offset));
    world_nxt = keep ? dpbp_pkg::sat_out(wsum) : '0;
  end

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      m0_r <= m0_nxt;
      m1_r <= m1_nxt;
    end
    if (ctl.load[1]) begin
      s_r <= s_nxt;
    end
    if (ctl.load[2]) begin
      pl_r <= pl_nxt;
      ph_r <= ph_nxt;
    end
    if (ctl.load[3]) begin
      r_r <= r_nxt;
    end
    if (ctl.load[4]) begin
      world_r <= world_nxt;
    end
  end

  assign world = world_r;

endmodule

>>> sv/depth_pixel_backprojection_unit.sv
// throughput: one pixel per cycle while out_tready holds; each stage holds under
// backpressure and bubbles close up, so a new request is taken while a result waits
// reset: synchronous active low, clears stage valid bits and loads the
// configuration registers with their default values
// ---------------------------------------------------------------------------
// depth_pixel_backprojection_unit
// depth pixel to world point backprojection, five stage pipeline
// ---------------------------------------------------------------------------
`include "depth_pixel_backprojection_unit_macros.svh"

module depth_pixel_backprojection_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [dpbp_pkg::AddrW-1:0]    cfg_addr,
  input  logic [dpbp_pkg::RegW-1:0]     cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // pixel_row[11:0], pixel_col[23:12], raw_depth[39:24]
  input  logic [39:0]                   in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // world_x[27:0], world_y[55:28], world_z[83:56], zero pad[87:84]
  output logic [87:0]                   out_tdata,
  // kept[0]
  output logic                          out_tuser
);

  localparam int NS = dpbp_pkg::Stages;
  localparam int OW = dpbp_pkg::OutW;
  localparam int CW = dpbp_pkg::CoefW;

  dpbp_pkg::cfg_t      cfg;
  dpbp_pkg::pipe_ctl_t ctl;

  logic [NS-1:0]                   v_r, v_nxt;
  logic [NS-1:0]                   rdy;
  logic [dpbp_pkg::PixW-1:0]       pixel_row;
  logic [dpbp_pkg::PixW-1:0]       pixel_col;
  logic [dpbp_pkg::RawW-1:0]       raw_depth;
  logic [dpbp_pkg::ProdW-1:0]      prod_r, prod_nxt;
  logic [dpbp_pkg::ProdW:0]        dsum;
  logic [dpbp_pkg::DistW-1:0]      d_r, d_nxt;
  logic                            keep2_r, keep2_nxt;
  logic                            keep3_r;
  logic                            keep4_r;
  logic                            keep5_r;
  logic signed [OW-1:0]            world [3];

  assign pixel_row = in_tdata[11:0];
  assign pixel_col = in_tdata[23:12];
  assign raw_depth = in_tdata[39:24];

  dpbp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // a stage loads when it is empty or its content moves on
  always_comb begin
    rdy[NS-1] = !v_r[NS-1] || out_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
    ctl.load = rdy;
    v_nxt[0] = rdy[0] ? in_tvalid : v_r[0];
    for (int i = 1; i < NS; i++) begin
      v_nxt[i] = rdy[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_comb begin
    prod_nxt  = dpbp_pkg::ProdW'(raw_depth) * dpbp_pkg::ProdW'(cfg.depth_scale);
    dsum      = {1'b0, prod_r} + (dpbp_pkg::ProdW + 1)'(2048);
    d_nxt     = dsum[dpbp_pkg::ProdW-1:12];
    keep2_nxt = (d_nxt > dpbp_pkg::DistW'(cfg.near_limit))
             && (d_nxt < dpbp_pkg::DistW'(cfg.far_limit));
  end

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      prod_r <= prod_nxt;
    end
    if (ctl.load[1]) begin
      d_r     <= d_nxt;
      keep2_r <= keep2_nxt;
    end
    if (ctl.load[2]) begin
      keep3_r <= keep2_r;
    end
    if (ctl.load[3]) begin
      keep4_r <= keep3_r;
    end
    if (ctl.load[4]) begin
      keep5_r <= keep4_r;
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    dpbp_axis u_axis (
      .clk       (clk),
      .ctl       (ctl),
      .pixel_col (pixel_col),
      .pixel_row (pixel_row),
      .coeffs    (cfg.coeffs[a]),
      .offset    (cfg.translation[a*CW +: CW]),
      .depth_d   (d_r),
      .keep      (keep4_r),
      .world     (world[a])
    );
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = v_r[NS-1];
  assign out_tuser  = keep5_r;
  assign out_tdata  = {4'b0, world[2], world[1], world[0]};

  `DPBP_ASSERT_SAME(a_drop_zero, out_tvalid && !out_tuser, out_tdata == '0)
  `DPBP_ASSERT_SAME(a_kept_limits, out_tvalid && out_tuser, cfg.near_limit < cfg.far_limit)
  `DPBP_ASSERT_NEXT(a_accept_fills, in_tvalid && in_tready, v_r[0])

endmodule

>>> sim/depth_pixel_backprojection_unit_test.sv
// ---------------------------------------------------------------------------
// depth_pixel_backprojection_unit_test
// streams depth pixels through the backprojection unit under several register
// settings and random handshake gaps, predicts every world point in a small
// scoreboard and compares the kept flag and all three coordinates per result
// ---------------------------------------------------------------------------
module depth_pixel_backprojection_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [dpbp_pkg::AddrW-1:0] RegSpare = 3'd7;
  localparam int HoldCycles   = 400;
  localparam int SettleCycles = 10;
  localparam int PhaseItems   = 116;
  localparam int RandPhases   = 8;
  localparam longint OutHi    = 134217727;
  localparam longint OutLo    = -134217728;

  typedef struct packed {
    logic                      kept;
    logic [dpbp_pkg::OutW-1:0] x;
    logic [dpbp_pkg::OutW-1:0] y;
    logic [dpbp_pkg::OutW-1:0] z;
  } world_point_t;

  class depth_checker;
    logic [dpbp_pkg::ScaleW-1:0] depth_scale;
    logic [dpbp_pkg::LimW-1:0]   near_limit;
    logic [dpbp_pkg::LimW-1:0]   far_limit;
    logic [dpbp_pkg::RegW-1:0]   coeffs [3];
    logic [dpbp_pkg::RegW-1:0]   trans;
    world_point_t                points_due [$];
    int mismatches;
    int pixels;
    int results;
    int kept_count;
    int clamp_count;

    function void load_defaults();
      depth_scale = dpbp_pkg::ScaleReset;
      near_limit  = dpbp_pkg::NearReset;
      far_limit   = dpbp_pkg::FarReset;
      foreach (coeffs[i]) coeffs[i] = '0;
      trans = '0;
    endfunction

    function void set_register(logic [dpbp_pkg::AddrW-1:0] idx,
                               logic [dpbp_pkg::RegW-1:0] value);
      case (idx)
        dpbp_pkg::RegDepthScale: depth_scale = value[dpbp_pkg::ScaleW-1:0];
        dpbp_pkg::RegNearLimit:  near_limit  = value[dpbp_pkg::LimW-1:0];
        dpbp_pkg::RegFarLimit:   far_limit   = value[dpbp_pkg::LimW-1:0];
        dpbp_pkg::RegXCoeffs:    coeffs[0]   = value;
        dpbp_pkg::RegYCoeffs:    coeffs[1]   = value;
        dpbp_pkg::RegZCoeffs:    coeffs[2]   = value;
        dpbp_pkg::RegTrans:      trans       = value;
        default: ;
      endcase
    endfunction

    function longint coef_field(logic [dpbp_pkg::RegW-1:0] word, int k);
      logic signed [dpbp_pkg::CoefW-1:0] f;
      f = word[k*dpbp_pkg::CoefW +: dpbp_pkg::CoefW];
      return f;
    endfunction

    function logic [dpbp_pkg::OutW-1:0] project_axis(logic [dpbp_pkg::RegW-1:0] word,
                                                     longint c, longint r,
                                                     longint depth_d, int k);
      longint s;
      longint p;
      longint w;
      s = coef_field(word, 0) * c + coef_field(word, 1) * r + coef_field(word, 2);
      p = s * depth_d;
      w = ((p + 64'sd131072) >>> dpbp_pkg::FracSh) + coef_field(trans, k);
      if (w > OutHi) begin
        w = OutHi;
        clamp_count++;
      end else if (w < OutLo) begin
        w = OutLo;
        clamp_count++;
      end
      return w[dpbp_pkg::OutW-1:0];
    endfunction

    function void note_pixel(logic [dpbp_pkg::PixW-1:0] row, logic [dpbp_pkg::PixW-1:0] col,
                             logic [dpbp_pkg::RawW-1:0] raw);
      longint r;
      longint c;
      longint rw;
      longint sc;
      longint depth_d;
      longint nl;
      longint fl;
      world_point_t pt;
      r = row;
      c = col;
      rw = raw;
      sc = depth_scale;
      nl = near_limit;
      fl = far_limit;
      depth_d = (rw * sc + 2048) >>> 12;
      pt = '0;
      pixels++;
      if (depth_d > nl && depth_d < fl) begin
        pt.kept = 1'b1;
        pt.x = project_axis(coeffs[0], c, r, depth_d, 0);
        pt.y = project_axis(coeffs[1], c, r, depth_d, 1);
        pt.z = project_axis(coeffs[2], c, r, depth_d, 2);
        kept_count++;
      end
      points_due.insert(points_due.size(), pt);
    endfunction

    task report(string msg);
      $display("tb: mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(logic [87:0] data, logic kept_flag);
      world_point_t want;
      if (points_due.size() == 0) begin
        report($sformatf("result with no request pending, kept %0b", kept_flag));
        return;
      end
      want = points_due.pop_front();
      results++;
      if (kept_flag !== want.kept)
        report($sformatf("kept expected %0b got %0b", want.kept, kept_flag));
      if (data[27:0] !== want.x)
        report($sformatf("world_x expected %0d got %0d", $signed(want.x), $signed(data[27:0])));
      if (data[55:28] !== want.y)
        report($sformatf("world_y expected %0d got %0d", $signed(want.y), $signed(data[55:28])));
      if (data[83:56] !== want.z)
        report($sformatf("world_z expected %0d got %0d", $signed(want.z), $signed(data[83:56])));
    endtask
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [dpbp_pkg::AddrW-1:0] cfg_addr = '0;
  logic [dpbp_pkg::RegW-1:0]  cfg_wdata = '0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [39:0]                in_tdata = '0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [87:0]                out_tdata;
  logic                       out_tuser;

  depth_checker sb = new();
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_armed = 1'b0;
  int  hold_left = 0;
  int  input_stalls = 0;
  int  settings = 1;

  depth_pixel_backprojection_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver side: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (hold_armed) begin
      hold_armed = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_pixel(in_tdata[11:0], in_tdata[23:12], in_tdata[39:24]);
      if (in_tvalid && !in_tready)
        input_stalls++;
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata, out_tuser);
    end
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [dpbp_pkg::RegW-1:0] pack3(int c0, int c1, int c2);
    logic [dpbp_pkg::CoefW-1:0] a;
    logic [dpbp_pkg::CoefW-1:0] b;
    logic [dpbp_pkg::CoefW-1:0] c;
    a = c0[dpbp_pkg::CoefW-1:0];
    b = c1[dpbp_pkg::CoefW-1:0];
    c = c2[dpbp_pkg::CoefW-1:0];
    return {c, b, a};
  endfunction

  function automatic logic [dpbp_pkg::RawW-1:0] pick_raw();
    longint lo;
    longint hi;
    longint sc;
    longint target;
    longint raw;
    lo = longint'(sb.near_limit) + 1;
    hi = longint'(sb.far_limit) - 1;
    sc = sb.depth_scale;
    if ($urandom_range(99) < 70 && sc != 0 && lo <= hi) begin
      target = lo + $urandom_range(int'(hi - lo));
      raw = (target << 12) / sc;
      if (raw <= 65535)
        return raw[dpbp_pkg::RawW-1:0];
    end
    return dpbp_pkg::RawW'($urandom_range(65535));
  endfunction

  function automatic logic [dpbp_pkg::RegW-1:0] random_word();
    return dpbp_pkg::RegW'({$urandom, $urandom});
  endfunction

  task automatic write_reg(logic [dpbp_pkg::AddrW-1:0] idx,
                           logic [dpbp_pkg::RegW-1:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_register(idx, value);
  endtask

  // upper bits beyond each register's width carry junk
  task automatic apply_config(logic [dpbp_pkg::ScaleW-1:0] scale,
                              logic [dpbp_pkg::LimW-1:0] near_lim,
                              logic [dpbp_pkg::LimW-1:0] far_lim,
                              logic [dpbp_pkg::RegW-1:0] cx,
                              logic [dpbp_pkg::RegW-1:0] cy, logic [dpbp_pkg::RegW-1:0] cz,
                              logic [dpbp_pkg::RegW-1:0] tr);
    logic [dpbp_pkg::RegW-1:0] junk;
    junk = random_word();
    write_reg(dpbp_pkg::RegDepthScale, {junk[dpbp_pkg::RegW-1:dpbp_pkg::ScaleW], scale});
    write_reg(dpbp_pkg::RegNearLimit, {junk[dpbp_pkg::RegW-1:dpbp_pkg::LimW], near_lim});
    write_reg(dpbp_pkg::RegFarLimit, {junk[dpbp_pkg::RegW-1:dpbp_pkg::LimW], far_lim});
    write_reg(dpbp_pkg::RegXCoeffs, cx);
    write_reg(dpbp_pkg::RegYCoeffs, cy);
    write_reg(dpbp_pkg::RegZCoeffs, cz);
    write_reg(dpbp_pkg::RegTrans, tr);
    write_reg(RegSpare, junk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic send_pixel(logic [dpbp_pkg::PixW-1:0] row, logic [dpbp_pkg::PixW-1:0] col,
                            logic [dpbp_pkg::RawW-1:0] raw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {raw, col, row};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.points_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic logic [dpbp_pkg::RegW-1:0] random_coeffs(bit wide);
    if (wide)
      return random_word();
    return pack3($urandom_range(8191) - 4096, $urandom_range(8191) - 4096,
                 $urandom_range(2097151) - 1048576);
  endfunction

  task automatic random_setting(int k);
    logic [dpbp_pkg::ScaleW-1:0] scale;
    logic [dpbp_pkg::LimW-1:0]   near_lim;
    logic [dpbp_pkg::LimW-1:0]   far_lim;
    longint                      top;
    if (k == 0) begin
      apply_config(24'hFFFFFF, '0, 20'hFFFFF, random_coeffs(1), random_coeffs(1),
                   random_coeffs(1), random_word());
    end else if (k == 1) begin
      apply_config(24'd1, '0, 20'd20, random_coeffs(0), random_coeffs(0),
                   random_coeffs(0), random_word());
    end else begin
      scale = ($urandom_range(3) == 0) ? dpbp_pkg::ScaleW'($urandom)
                                       : dpbp_pkg::ScaleW'($urandom_range(40000, 1000));
      near_lim = dpbp_pkg::LimW'($urandom_range(4095));
      top = longint'(near_lim) + $urandom_range(300000, 1);
      far_lim = (top > 20'hFFFFF) ? 20'hFFFFF : top[dpbp_pkg::LimW-1:0];
      apply_config(scale, near_lim, far_lim, random_coeffs(k[0]), random_coeffs(k[0]),
                   random_coeffs(0), random_word());
    end
  endtask

  initial begin
    sb.load_defaults();
    send_idle_pct = 38;
    recv_idle_pct = 76;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // default registers: near and far edges, zero depth, field extremes
    send_pixel(12'd0, 12'd0, 16'd0);
    send_pixel(12'd4095, 12'd4095, 16'd65535);
    send_pixel(12'd10, 12'd20, 16'd20);
    send_pixel(12'd10, 12'd20, 16'd21);
    send_pixel(12'd300, 12'd400, 16'd5000);
    send_pixel(12'd300, 12'd400, 16'd4999);
    drain();

    // unit scale so depth equals raw; extreme coefficients drive clamping
    apply_config(24'd4096, 20'd100, 20'd60000,
                 pack3(-1048576, 1048575, 0),
                 pack3(1048575, 0, 1048575),
                 pack3(524, -524, -1048576),
                 pack3(-1048576, 1048575, 4096));
    send_pixel(12'd0, 12'd0, 16'd100);
    send_pixel(12'd0, 12'd0, 16'd101);
    send_pixel(12'd0, 12'd4095, 16'd59999);
    send_pixel(12'd4095, 12'd0, 16'd59999);
    send_pixel(12'd4095, 12'd4095, 16'd59999);
    send_pixel(12'd2048, 12'd1024, 16'd60000);
    send_pixel(12'd0, 12'd0, 16'd65535);
    send_pixel(12'd1, 12'd1, 16'd30000);
    drain();

    // crossed limits drop everything
    apply_config(24'hFFFFFF, 20'hFFFFF, '0, pack3(1, 1, 1), pack3(1, 1, 1),
                 pack3(1, 1, 1), pack3(7, 7, 7));
    send_pixel(12'd5, 12'd5, 16'd0);
    send_pixel(12'd5, 12'd5, 16'd3000);
    send_pixel(12'd4095, 12'd0, 16'd65535);
    drain();

    for (int k = 0; k < RandPhases; k++) begin
      if (k < 3) begin
        send_idle_pct = 38;
        recv_idle_pct = 76;
      end else if (k < 6) begin
        send_idle_pct = 76;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_setting(k);
      if (k == 6)
        hold_armed = 1'b1;
      repeat (PhaseItems)
        send_pixel(dpbp_pkg::PixW'($urandom_range(4095)),
                   dpbp_pkg::PixW'($urandom_range(4095)), pick_raw());
      drain();
    end

    $display("tb: %0d pixels checked across %0d register settings, %0d kept, %0d dropped",
             sb.results, settings, sb.kept_count, sb.pixels - sb.kept_count);
    $display("tb: %0d coordinates clamped, input held off for %0d cycles",
             sb.clamp_count, input_stalls);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
